FILE: hw/rtl/lpsr_pkg.sv
// ----------------------------------------------------------------------------
// lpsr_pkg
// Shared sizes, status codes, function codes and controller/datapath structs
// for the length-prefixed string ring.
// ----------------------------------------------------------------------------
package lpsr_pkg;

  // Ring geometry (power of two)
  localparam int RING_DEPTH = 64;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int FREE_W     = ADDR_W + 1;

  // Item field widths
  localparam int FUNC_W   = 2;
  localparam int LEN_W    = 6;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;

  // Width wide enough to compare packet size against free room
  localparam int CMP_W = (FREE_W > LEN_W + 1) ? FREE_W : LEN_W + 1;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_PUSH_HDR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_CHAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POP       = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY         = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DATA         = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY_STRING = 3'd5;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;       // run a one-result item (push, rejected or deferred pop)
    logic pop_start;  // accept a pop and fetch its header byte
    logic hdr_load;   // header byte is back: load count, advance read index
    logic emit;       // send one character of the run
  } lpsr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pop_go;     // incoming item is a pop that will produce a run
    logic hdr_empty;  // fetched header describes an empty string
    logic last_char;  // the character now emitted is the last of the run
  } lpsr_stat_t;

endpackage

FILE: hw/rtl/lpsr_ctrl.sv
// ----------------------------------------------------------------------------
// lpsr_ctrl
// Controller state machine: accepts items, sequences header fetch and the
// character run of a pop, and paces the run against the output register.
// ----------------------------------------------------------------------------
module lpsr_ctrl
  import lpsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_valid,
  input  logic       out_ready,
  input  lpsr_stat_t dp_stat,
  output lpsr_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  // Output register can take a result this cycle
  assign slot_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          if (dp_stat.pop_go) begin
            cmd.pop_start = 1'b1;
            state_next    = S_HDR;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      S_HDR: begin
        cmd.hdr_load = 1'b1;
        state_next   = dp_stat.hdr_empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (dp_stat.last_char) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/lpsr_datapath.sv
// ----------------------------------------------------------------------------
// lpsr_datapath
// Byte ring memory, read/write indices, pending character count, run counter
// and the output result register.
// ----------------------------------------------------------------------------
module lpsr_datapath
  import lpsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  lpsr_cmd_t           cmd,
  output lpsr_stat_t          dp_stat,
  input  logic [FUNC_W-1:0]   func,
  input  logic [LEN_W-1:0]    str_length,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic                tx_busy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [CHAR_W-1:0]   char_out,
  output logic                last,
  output logic [FREE_W-1:0]   free_space
);

  logic [CHAR_W-1:0] mem [RING_DEPTH];

  logic [ADDR_W-1:0] read_index;
  logic [ADDR_W-1:0] read_index_next;
  logic [ADDR_W-1:0] write_index;
  logic [ADDR_W-1:0] write_index_next;
  logic [LEN_W-1:0]  chars_to_write;
  logic [LEN_W-1:0]  chars_to_write_next;
  logic [LEN_W-1:0]  count;
  logic [FREE_W-1:0] free_hold;
  logic [CHAR_W-1:0] rdata;

  logic [ADDR_W-1:0]   occupied;
  logic [FREE_W-1:0]   room;
  logic [FREE_W-1:0]   room_after;
  logic [ADDR_W-1:0]   occ_after_pop;
  logic [FREE_W-1:0]   free_after_pop;
  logic                is_empty;
  logic [CMP_W-1:0]    packet;
  logic                hdr_ok;
  logic                char_ok;
  logic                wr_en;
  logic [CHAR_W-1:0]   wr_data;
  logic                rd_en;
  logic [LEN_W-1:0]    hdr_n;
  logic [STATUS_W-1:0] exec_status;

  // Occupancy and free room of the ring as it stands
  assign occupied = write_index - read_index;
  assign room     = FREE_W'(RING_DEPTH) - {1'b0, occupied};
  assign is_empty = (read_index == write_index);

  // Header fetched from the ring: character count of the packet
  assign hdr_n = (rdata == '0) ? '0 : LEN_W'(rdata - CHAR_W'(1));

  // Push decisions
  assign packet  = CMP_W'(str_length) + CMP_W'(1);
  assign hdr_ok  = (chars_to_write == '0) && (packet < CMP_W'(room));
  assign char_ok = (chars_to_write != '0);

  // Status back to the controller
  assign dp_stat.pop_go    = (func == FN_POP) && !is_empty && !tx_busy &&
                             (chars_to_write == '0);
  assign dp_stat.hdr_empty = (hdr_n == '0);
  assign dp_stat.last_char = (count == LEN_W'(1));

  // Write side and result code of a one-result item
  always_comb begin
    wr_en               = 1'b0;
    wr_data             = char_in;
    write_index_next    = write_index;
    chars_to_write_next = chars_to_write;
    exec_status         = ST_REJECTED;
    case (func)
      FN_PUSH_HDR: begin
        if (hdr_ok) begin
          exec_status = ST_ACCEPTED;
          if (cmd.exec) begin
            wr_en               = 1'b1;
            wr_data             = CHAR_W'(packet);
            write_index_next    = write_index + ADDR_W'(1);
            chars_to_write_next = str_length;
          end
        end
      end
      FN_PUSH_CHAR: begin
        if (char_ok) begin
          exec_status = ST_ACCEPTED;
          if (cmd.exec) begin
            wr_en               = 1'b1;
            write_index_next    = write_index + ADDR_W'(1);
            chars_to_write_next = chars_to_write - LEN_W'(1);
          end
        end
      end
      FN_POP: begin
        exec_status = is_empty ? ST_EMPTY : ST_BUSY;
      end
      default: begin
        exec_status = ST_REJECTED;
      end
    endcase
  end

  // Free room after a one-result item
  assign room_after = FREE_W'(RING_DEPTH) - {1'b0, write_index_next - read_index};

  // Free room once the whole packet at the read index is gone
  assign occ_after_pop  = write_index - read_index - ADDR_W'(1) - ADDR_W'(hdr_n);
  assign free_after_pop = FREE_W'(RING_DEPTH) - {1'b0, occ_after_pop};

  // Read index advances past the header and past each emitted character
  assign read_index_next = (cmd.hdr_load || cmd.emit) ? read_index + ADDR_W'(1)
                                                      : read_index;

  // Fetch the byte at the next read position when the run needs it
  assign rd_en = cmd.pop_start || (cmd.hdr_load && (hdr_n != '0)) ||
                 (cmd.emit && !dp_stat.last_char);

  // Ring memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_index] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[read_index_next];
    end
  end

  // Indices and pending character count
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index     <= '0;
      write_index    <= '0;
      chars_to_write <= '0;
    end else begin
      read_index     <= read_index_next;
      write_index    <= write_index_next;
      chars_to_write <= chars_to_write_next;
    end
  end

  // Run counter and free room carried by every result of the run
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.hdr_load) begin
      count <= hdr_n;
    end else if (cmd.emit) begin
      count <= count - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_load) begin
      free_hold <= free_after_pop;
    end
  end

  // Output result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec || cmd.emit || (cmd.hdr_load && dp_stat.hdr_empty)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= exec_status;
      char_out   <= '0;
      last       <= 1'b1;
      free_space <= room_after;
    end else if (cmd.hdr_load && dp_stat.hdr_empty) begin
      status     <= ST_EMPTY_STRING;
      char_out   <= '0;
      last       <= 1'b1;
      free_space <= free_after_pop;
    end else if (cmd.emit) begin
      status     <= ST_DATA;
      char_out   <= rdata;
      last       <= dp_stat.last_char;
      free_space <= free_hold;
    end
  end

  // A run only emits while characters remain
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (count != '0))
    else $error("emit with empty run counter");

  // Emit and one-result loads never overrun a waiting result
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.exec) |-> (!out_valid || out_ready))
    else $error("result register overrun");

  // Characters still owed always fit, keeping one slot free
  a_reserve_fits: assert property (@(posedge clk) disable iff (rst)
    (chars_to_write != '0) |->
      ((CMP_W + 1)'(occupied) + (CMP_W + 1)'(chars_to_write) <
       (CMP_W + 1)'(RING_DEPTH)))
    else $error("pending characters exceed free room");

  // No write lands while a pop run is in progress
  a_no_write_in_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.hdr_load || cmd.emit) |-> !wr_en)
    else $error("ring write during pop run");

endmodule

FILE: hw/rtl/length_prefixed_string_ring_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_string_ring_top
// A push-header, push-char, unused-selector or deferred/empty pop item gives
// one result; the next item is taken in the following cycle only if the
// output register is then empty or its result leaves at that edge, so a
// result held by out_ready low stalls the input. A pop that finds a packet
// of n characters first does the registered read of the header byte from
// the ring memory, then loads its count, then sends one character per cycle
// while out_ready stays high. No item is taken during a run. The ring holds
// RING_DEPTH bytes with one slot always left free; free_space reports the
// room after the whole item, the same on each result.
// ----------------------------------------------------------------------------
module length_prefixed_string_ring_top
  import lpsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [LEN_W-1:0]    str_length,
  input  logic [CHAR_W-1:0]   char_in,
  input  logic                tx_busy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [CHAR_W-1:0]   char_out,
  output logic                last,
  output logic [FREE_W-1:0]   free_space
);

  lpsr_cmd_t  cmd;
  lpsr_stat_t dp_stat;

  // Sequencer
  lpsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  // Ring storage and result register
  lpsr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .dp_stat    (dp_stat),
    .func       (func),
    .str_length (str_length),
    .char_in    (char_in),
    .tx_busy    (tx_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .char_out   (char_out),
    .last       (last),
    .free_space (free_space)
  );

endmodule

FILE: bench/length_prefixed_string_ring_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_string_ring_top_tb
// Drives push-header, push-char, pop and unused-selector items through the
// string ring under random sender and receiver idling, predicts every result
// from a behavioral copy of the ring, and checks the results in order.
// ----------------------------------------------------------------------------
module length_prefixed_string_ring_top_tb;
  import lpsr_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 100;
  localparam int RANDOM_ITEMS = 130;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [LEN_W-1:0]  str_length;
    logic [CHAR_W-1:0] char_in;
    logic              tx_busy;
  } ring_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   char_out;
    logic                last;
    logic [FREE_W-1:0]   free_space;
  } ring_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   func;
  logic [LEN_W-1:0]    str_length;
  logic [CHAR_W-1:0]   char_in;
  logic                tx_busy;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [CHAR_W-1:0]   char_out;
  logic                last;
  logic [FREE_W-1:0]   free_space;

  // Items waiting to be sent and results owed by the block
  ring_item_t   queued_items[$];
  ring_result_t owed_results[$];
  int           total_items;
  int           n_driven;
  int           n_accepted;
  int           fail_count;
  int           cycle_count;

  // Shadow copy of the ring
  logic [CHAR_W-1:0] shadow_store[RING_DEPTH];
  logic [ADDR_W-1:0] shadow_rd;
  logic [ADDR_W-1:0] shadow_wr;
  logic [LEN_W-1:0]  shadow_owed;

  length_prefixed_string_ring_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .str_length (str_length),
    .char_in    (char_in),
    .tx_busy    (tx_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .char_out   (char_out),
    .last       (last),
    .free_space (free_space)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Room left in the shadow ring: depth minus occupied slots
  function automatic logic [FREE_W-1:0] shadow_room();
    logic [ADDR_W-1:0] used;
    used = shadow_wr - shadow_rd;
    return FREE_W'(RING_DEPTH) - FREE_W'(used);
  endfunction

  // Apply one item to the shadow ring and queue the results it must produce
  task automatic apply_ring_item(input ring_item_t it);
    ring_result_t run[$];
    ring_result_t r;
    logic [CHAR_W-1:0] hdr;
    int n;
    r = '{ST_REJECTED, '0, 1'b1, '0};
    case (it.func)
      FN_PUSH_HDR: begin
        if (shadow_owed == 0 && int'(it.str_length) + 1 < int'(shadow_room())) begin
          shadow_store[shadow_wr] = CHAR_W'(it.str_length) + 8'd1;
          shadow_wr = shadow_wr + 1'b1;
          shadow_owed = it.str_length;
          r.status = ST_ACCEPTED;
        end
        run.push_back(r);
      end
      FN_PUSH_CHAR: begin
        if (shadow_owed != 0) begin
          shadow_store[shadow_wr] = it.char_in;
          shadow_wr = shadow_wr + 1'b1;
          shadow_owed = shadow_owed - 1'b1;
          r.status = ST_ACCEPTED;
        end
        run.push_back(r);
      end
      FN_POP: begin
        if (shadow_rd == shadow_wr) begin
          r.status = ST_EMPTY;
          run.push_back(r);
        end else if (it.tx_busy || shadow_owed != 0) begin
          r.status = ST_BUSY;
          run.push_back(r);
        end else begin
          hdr = shadow_store[shadow_rd];
          shadow_rd = shadow_rd + 1'b1;
          n = (hdr == 0) ? 0 : int'(hdr) - 1;
          if (n == 0) begin
            r.status = ST_EMPTY_STRING;
            run.push_back(r);
          end
          for (int i = 0; i < n; i++) begin
            r.status = ST_DATA;
            r.char_out = shadow_store[shadow_rd];
            r.last = (i == n - 1);
            shadow_rd = shadow_rd + 1'b1;
            run.push_back(r);
          end
        end
      end
      default: begin
        run.push_back(r);
      end
    endcase
    // Every result of one item reports the room after the whole item
    foreach (run[i]) begin
      run[i].free_space = shadow_room();
      owed_results.push_back(run[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  task automatic add_item(input logic [FUNC_W-1:0] f, input logic [LEN_W-1:0] len,
                          input logic [CHAR_W-1:0] ch, input logic busy);
    ring_item_t it;
    it = '{f, len, ch, busy};
    queued_items.push_back(it);
  endtask

  // Push a string packet, cut short now and then
  task automatic add_packet();
    int pick;
    int len;
    int sent;
    pick = $urandom_range(0, 99);
    if (pick < 6) len = RING_DEPTH - 2;
    else if (pick < 16) len = $urandom_range(9, RING_DEPTH - 3);
    else len = $urandom_range(0, 8);
    add_item(FN_PUSH_HDR, LEN_W'(len), CHAR_W'($urandom), 1'($urandom));
    sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
    for (int i = 0; i < sent; i++) begin
      add_item(FN_PUSH_CHAR, LEN_W'($urandom), CHAR_W'($urandom), 1'($urandom));
    end
  endtask

  // Check results, then predict from any item taken at this edge
  always @(posedge clk) begin
    ring_result_t want;
    ring_item_t   got_item;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: status %0d, char_out %0d", status, char_out);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("char_out", 32'(want.char_out), 32'(char_out));
          compare_field("last", 32'(want.last), 32'(last));
          compare_field("free_space", 32'(want.free_space), 32'(free_space));
        end
      end
      if (in_valid && in_ready) begin
        got_item = '{func, str_length, char_in, tx_busy};
        apply_ring_item(got_item);
        n_accepted++;
      end
    end
  end

  // Present items and idle both sides at the rate of the current phase
  always @(negedge clk) begin
    ring_item_t it;
    int phase;
    int send_idle;
    int recv_idle;
    if (!rst) begin
      phase = (total_items == 0) ? 2 : (n_driven * 3) / total_items;
      send_idle = (phase == 0) ? 25 : (phase == 1) ? 49 : 0;
      recv_idle = (phase == 0) ? 49 : (phase == 1) ? 25 : 0;
      // Hold the current item until it is taken
      if (n_accepted == n_driven) begin
        if (queued_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          it = queued_items.pop_front();
          func       <= it.func;
          str_length <= it.str_length;
          char_in    <= it.char_in;
          tx_busy    <= it.tx_busy;
          in_valid   <= 1'b1;
          n_driven++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    int pick;
    int added;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_PUSH_HDR;
    str_length = '0;
    char_in = '0;
    tx_busy = 1'b0;
    out_ready = 1'b0;
    n_driven = 0;
    n_accepted = 0;
    fail_count = 0;
    cycle_count = 0;
    shadow_rd = '0;
    shadow_wr = '0;
    shadow_owed = '0;

    // Directed: empty ring, stray char, unused selector, no room, empty
    // string, busy pops, header during a packet, extreme characters
    add_item(FN_POP, 6'd0, 8'h00, 1'b0);
    add_item(FN_PUSH_CHAR, 6'd0, 8'h5A, 1'b0);
    add_item(FN_UNUSED, 6'd63, 8'hFF, 1'b1);
    add_item(FN_PUSH_HDR, 6'd63, 8'hFF, 1'b1);
    add_item(FN_PUSH_HDR, 6'd0, 8'h00, 1'b0);
    add_item(FN_POP, 6'd0, 8'h00, 1'b1);
    add_item(FN_POP, 6'd63, 8'hFF, 1'b0);
    add_item(FN_PUSH_HDR, 6'd2, 8'h00, 1'b0);
    add_item(FN_POP, 6'd0, 8'h00, 1'b0);
    add_item(FN_PUSH_HDR, 6'd1, 8'h00, 1'b0);
    add_item(FN_PUSH_CHAR, 6'd63, 8'h00, 1'b1);
    add_item(FN_PUSH_CHAR, 6'd0, 8'hFF, 1'b0);
    add_item(FN_PUSH_CHAR, 6'd0, 8'h33, 1'b0);
    add_item(FN_POP, 6'd0, 8'h00, 1'b1);
    add_item(FN_POP, 6'd0, 8'h00, 1'b0);
    add_item(FN_POP, 6'd0, 8'h00, 1'b0);

    // Random: mostly packets and pops, the rest noise on every field
    added = queued_items.size();
    while (queued_items.size() - added < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        add_packet();
      end else if (pick < 85) begin
        add_item(FN_POP, LEN_W'($urandom), CHAR_W'($urandom), $urandom_range(0, 4) == 0);
      end else begin
        add_item(FUNC_W'($urandom), LEN_W'($urandom), CHAR_W'($urandom), 1'($urandom));
      end
    end
    total_items = queued_items.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain, then give stray results time to show up
    while (!(n_accepted == total_items && owed_results.size() == 0)
           && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (fail_count == 0 && owed_results.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lpsr_pkg.sv
hw/rtl/lpsr_ctrl.sv
hw/rtl/lpsr_datapath.sv
hw/rtl/length_prefixed_string_ring_top.sv
bench/length_prefixed_string_ring_top_tb.sv
